[design/poc_pkg.sv]
// shared types and codes for the partial order closure block
package poc_pkg;

  localparam int unsigned ELEM_W = 6;
  localparam int unsigned CNT_W  = 7;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] REL_NONE = 2'd0;
  localparam logic [1:0] REL_A_GT = 2'd1;
  localparam logic [1:0] REL_B_GT = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  typedef enum logic [1:0] {
    RD_A = 2'd0,
    RD_B = 2'd1,
    RD_X = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic    clr;
    logic    load;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    cap_a;
    logic    cap_b;
    logic    walk_start;
    logic    walk_step;
    logic    res_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic oor;
    logic is_add;
    logic reject;
    logic walk_done;
  } sts_t;

endpackage

[design/poc_datapath.sv]
// row memory, item registers, row walk and result registers
module poc_datapath #(
  parameter int unsigned MAX_ELEMS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [poc_pkg::CNT_W-1:0] cfg_wdata_i,
  input  logic                     op_i,
  input  logic [poc_pkg::ELEM_W-1:0] elem_a_i,
  input  logic [poc_pkg::ELEM_W-1:0] elem_b_i,
  input  poc_pkg::cmd_t            cmd_i,
  output poc_pkg::sts_t            sts_o,
  output logic [1:0]               relation_o,
  output logic [1:0]               status_o
);
  import poc_pkg::*;

  localparam int unsigned AW    = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int unsigned N_RST = (MAX_ELEMS < 64) ? MAX_ELEMS : 64;

  logic [CNT_W-1:0]     n_q, n_d;
  logic                 op_q;
  logic [ELEM_W-1:0]    a_q, b_q;
  logic                 gt_ab_q, gt_ba_q;
  logic [MAX_ELEMS-1:0] row_b_q;
  logic [MAX_ELEMS-1:0] mem [MAX_ELEMS];
  logic [MAX_ELEMS-1:0] rdata_q;
  logic [CNT_W-1:0]     x_q, x_d;
  logic [CNT_W-1:0]     stg_x_q, stg_x_d;
  logic                 stg_v_q, stg_v_d;
  logic [AW-1:0]        clr_q;
  logic [1:0]           rel_q, sts_q;

  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [MAX_ELEMS-1:0] wdata;
  logic [MAX_ELEMS-1:0] sh_a, sh_b, one_b;
  logic                 x_in;
  logic [1:0]           rel;

  // saturate the element count to the matrix size
  always_comb begin
    n_d = n_q;
    if (cfg_we_i) begin
      if (32'(cfg_wdata_i) > MAX_ELEMS) n_d = CNT_W'(MAX_ELEMS);
      else n_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) n_q <= CNT_W'(N_RST);
    else n_q <= n_d;
  end

  assign sh_a  = rdata_q >> a_q;
  assign sh_b  = rdata_q >> b_q;
  assign one_b = {{(MAX_ELEMS-1){1'b0}}, 1'b1} << b_q;
  assign x_in  = x_q < n_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i;
      a_q  <= elem_a_i;
      b_q  <= elem_b_i;
    end
    if (cmd_i.cap_a) gt_ab_q <= sh_b[0];
    if (cmd_i.cap_b) begin
      gt_ba_q <= sh_a[0];
      row_b_q <= rdata_q | one_b;
    end
  end

  // row walk: read row x, write it back in the next cycle if x is a or lies above a
  always_comb begin
    x_d     = x_q;
    stg_v_d = stg_v_q;
    stg_x_d = stg_x_q;
    if (cmd_i.walk_start) begin
      x_d     = '0;
      stg_v_d = 1'b0;
    end else if (cmd_i.walk_step) begin
      stg_v_d = x_in;
      stg_x_d = x_q;
      if (x_in) x_d = x_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q     <= '0;
      stg_v_q <= 1'b0;
      clr_q   <= '0;
    end else begin
      x_q     <= x_d;
      stg_v_q <= stg_v_d;
      if (cmd_i.clr) clr_q <= clr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    stg_x_q <= stg_x_d;
  end

  always_comb begin
    rd_en = cmd_i.rd_en || (cmd_i.walk_step && x_in);
    case (cmd_i.rd_sel)
      RD_A:    rd_addr = AW'(a_q);
      RD_B:    rd_addr = AW'(b_q);
      RD_X:    rd_addr = AW'(x_q);
      default: rd_addr = AW'(x_q);
    endcase
    if (cmd_i.walk_step) rd_addr = AW'(x_q);
  end

  always_comb begin
    if (cmd_i.clr) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = '0;
    end else begin
      we    = cmd_i.walk_step && stg_v_q && ((stg_x_q == {1'b0, a_q}) || sh_a[0]);
      waddr = AW'(stg_x_q);
      wdata = rdata_q | row_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  assign rel = gt_ab_q ? REL_A_GT : (gt_ba_q ? REL_B_GT : REL_NONE);

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      if (sts_o.oor) begin
        rel_q <= REL_NONE;
        sts_q <= ST_RANGE;
      end else begin
        rel_q <= rel;
        sts_q <= (sts_o.is_add && sts_o.reject) ? ST_REJECT : ST_OK;
      end
    end
  end

  assign sts_o.clr_last  = (clr_q == AW'(MAX_ELEMS - 1));
  assign sts_o.oor       = ({1'b0, a_q} >= n_q) || ({1'b0, b_q} >= n_q);
  assign sts_o.is_add    = (op_q == OP_ADD);
  assign sts_o.reject    = (a_q == b_q) || gt_ab_q || gt_ba_q;
  assign sts_o.walk_done = !x_in && !stg_v_q;

  assign relation_o = rel_q;
  assign status_o   = sts_q;

endmodule

[design/poc_ctrl.sv]
// sequencing state machine and output beat handshake
module poc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  poc_pkg::sts_t sts_i,
  output poc_pkg::cmd_t cmd_o
);
  import poc_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_RD_A   = 7'b0000100,
    S_RD_B   = 7'b0001000,
    S_CAP_B  = 7'b0010000,
    S_WALK   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   check_q, check_d;

  always_comb begin
    state_d     = state_q;
    check_d     = 1'b0;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.rd_sel = RD_X;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RD_A;
        end
      end
      S_RD_A: begin
        if (sts_i.oor) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_A;
          state_d      = S_RD_B;
        end
      end
      S_RD_B: begin
        cmd_o.cap_a  = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_B;
        state_d      = S_CAP_B;
      end
      S_CAP_B: begin
        // capture row b, then decide in the next cycle with both bits registered
        if (!check_q) begin
          cmd_o.cap_b = 1'b1;
          check_d     = 1'b1;
        end else if (sts_i.is_add && !sts_i.reject) begin
          cmd_o.walk_start = 1'b1;
          state_d          = S_WALK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.walk_done) state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
      check_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      check_q     <= check_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[design/partial_order_closure.sv]
// top level of the partial order closure block
// Keeps a transitively closed "greater than" bit matrix, one row per element, in a
// single-port-read, single-port-write row memory. After reset the block clears the
// memory, one row a cycle, and accepts no item meanwhile. The user must write the
// element count register only between items, while none is in flight; the block
// itself does not enforce this. One item is worked at a time. An out of range item
// goes from the range check straight to the result; a query or an add reads row a
// and row b and decides from both bits; an accepted add then runs the walk, which
// reads each row in use once and writes back those at or above a. The input is
// ready again the cycle after the result loads. A finished result waits in the
// output register while the next item is taken in; a result still held by a
// stalled output beat delays only the loading of the next one.
module partial_order_closure #(
  parameter int unsigned MAX_ELEMS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,     // elements_in_use
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,    // elem_a [5:0], elem_b [11:6], zero [15:12]
  input  logic        s_axis_tuser,    // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata     // relation [1:0], status [3:2], zero [7:4]
);
  import poc_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic [1:0] relation, status;

  poc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  poc_datapath #(
    .MAX_ELEMS (MAX_ELEMS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_i        (s_axis_tuser),
    .elem_a_i    (s_axis_tdata[5:0]),
    .elem_b_i    (s_axis_tdata[11:6]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .relation_o  (relation),
    .status_o    (status)
  );

  assign m_axis_tdata = {4'b0000, status, relation};

endmodule

[design/poc_checker.sv]
// port level checks for the partial order closure block
module poc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);
  import poc_pkg::*;

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // an out of range item never reports an order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[3:2] == ST_RANGE) |-> (m_axis_tdata[1:0] == REL_NONE))
    else $error("out of range result carries a relation");

  // one item in flight: no second beat right after an accepted one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // the matrix clear runs before any item is taken
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("input ready during clear");

  // a result never reports both orders
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
    else $error("invalid relation code");

endmodule

bind partial_order_closure poc_checker u_poc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
